FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  `ASSERT_PROP(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

FILE: rtl/fbsc_pkg.sv
// ----------------------------------------------------------------------------
// fbsc_pkg
// Shared types and constants of the FAT boot sector check pipeline.
// ----------------------------------------------------------------------------
package fbsc_pkg;

  // Rejection reasons, first failing check wins
  typedef enum logic [3:0] {
    RSN_OK       = 4'd0,
    RSN_SMALL    = 4'd1,
    RSN_NOSIG    = 4'd2,
    RSN_SECTOR   = 4'd3,
    RSN_CLUSTER  = 4'd4,
    RSN_COUNTS   = 4'd5,
    RSN_ZERO     = 4'd6,
    RSN_GEOMETRY = 4'd7,
    RSN_NOCLUST  = 4'd8
  } reason_t;

  localparam logic [15:0] BOOT_SIG           = 16'hAA55;
  // 64 KiB minimum partition: bits 16 and up must not all be zero
  localparam int          MIN_PART_LOG2      = 16;
  localparam int          SECTOR_MIN_LOG2    = 9;
  localparam logic [31:0] FAT32_MIN_CLUSTERS = 32'd65525;
  localparam int          LATENCY            = 4;

  // After the field checks
  typedef struct packed {
    reason_t     reason;
    logic [1:0]  bps_code;   // log2(bytes per sector) - 9
    logic [2:0]  spc_log2;
    logic [15:0] rsvd;
    logic [32:0] fat_total;  // FAT count times FAT size
    logic [12:0] root_secs;
    logic [31:0] tot;
  } s1_t;

  // After the geometry sum
  typedef struct packed {
    reason_t     reason;
    logic [1:0]  bps_code;
    logic [2:0]  spc_log2;
    logic [33:0] used;
    logic [31:0] tot;
  } s2_t;

  // After the fit test
  typedef struct packed {
    reason_t     reason;
    logic [1:0]  bps_code;
    logic [2:0]  spc_log2;
    logic [31:0] data_secs;
  } s3_t;

endpackage

FILE: rtl/fat_boot_sector_check_unit.sv
// ----------------------------------------------------------------------------
// fat_boot_sector_check_unit
// Validates the parameter block of a FAT boot sector against its partition.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the boot sector fields and the partition size on the in_ ports and
//   raise start; the item is taken at the clock edge where start is high and
//   busy is low. busy is low whenever the block is out of reset, so one item
//   may be issued in every cycle.
//   Each result appears on the out_ ports for exactly one cycle with
//   out_valid high. Results leave in issue order. The receiver cannot
//   hold results off, and the block needs no back pressure: each of the
//   four register stages (field checks, geometry sum, fit test, cluster
//   division and result register) advances every cycle, so throughput is
//   one item per cycle.
//   A rejected item reports the first failing check in out_reject_reason and
//   zero cluster size, cluster count and label select.
//   Reset (rst_n low, synchronous) drops every item in flight; busy stays
//   high while reset is held.
// ----------------------------------------------------------------------------
module fat_boot_sector_check_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_partition_bytes,
  input  logic [15:0] in_boot_signature,
  input  logic [15:0] in_bytes_per_sector,
  input  logic [7:0]  in_sectors_per_cluster,
  input  logic [15:0] in_reserved_sectors,
  input  logic [7:0]  in_fat_count,
  input  logic [15:0] in_root_entries,
  input  logic [15:0] in_total_sectors_short,
  input  logic [15:0] in_fat_sectors_short,
  input  logic [31:0] in_total_sectors_long,
  input  logic [31:0] in_fat_sectors_long,
  output logic        out_valid,
  output logic        out_accepted,
  output logic [3:0]  out_reject_reason,
  output logic        out_signature_seen,
  output logic [19:0] out_cluster_bytes,
  output logic [31:0] out_cluster_count,
  output logic        out_label_at_fat32_offset
);
  import fbsc_pkg::*;

  logic in_take;
  logic s1_valid;
  s1_t  s1;
  logic s3_valid;
  s3_t  s3;

  // Take an item whenever out of reset
  assign busy    = !rst_n;
  assign in_take = start && !busy;

  fbsc_check u_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_take),
    .partition_bytes     (in_partition_bytes),
    .boot_signature      (in_boot_signature),
    .bytes_per_sector    (in_bytes_per_sector),
    .sectors_per_cluster (in_sectors_per_cluster),
    .reserved_sectors    (in_reserved_sectors),
    .fat_count           (in_fat_count),
    .root_entries        (in_root_entries),
    .total_sectors_short (in_total_sectors_short),
    .fat_sectors_short   (in_fat_sectors_short),
    .total_sectors_long  (in_total_sectors_long),
    .fat_sectors_long    (in_fat_sectors_long),
    .s1_valid_r          (s1_valid),
    .s1_r                (s1)
  );

  fbsc_geom u_geom (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid_r (s1_valid),
    .s1_r       (s1),
    .s3_valid_r (s3_valid),
    .s3_r       (s3)
  );

  fbsc_result u_result (
    .clk                  (clk),
    .rst_n                (rst_n),
    .s3_valid_r           (s3_valid),
    .s3_r                 (s3),
    .out_valid_r          (out_valid),
    .out_accepted_r       (out_accepted),
    .out_reject_reason_r  (out_reject_reason),
    .out_signature_seen_r (out_signature_seen),
    .out_cluster_bytes_r  (out_cluster_bytes),
    .out_cluster_count_r  (out_cluster_count),
    .out_label_r          (out_label_at_fat32_offset)
  );

endmodule

FILE: rtl/fbsc_check.sv
// ----------------------------------------------------------------------------
// fbsc_check
// First stage: field checks, size selection and root directory sectors.
// ----------------------------------------------------------------------------
module fbsc_check (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [63:0]   partition_bytes,
  input  logic [15:0]   boot_signature,
  input  logic [15:0]   bytes_per_sector,
  input  logic [7:0]    sectors_per_cluster,
  input  logic [15:0]   reserved_sectors,
  input  logic [7:0]    fat_count,
  input  logic [15:0]   root_entries,
  input  logic [15:0]   total_sectors_short,
  input  logic [15:0]   fat_sectors_short,
  input  logic [31:0]   total_sectors_long,
  input  logic [31:0]   fat_sectors_long,
  output logic          s1_valid_r,
  output fbsc_pkg::s1_t s1_r
);
  import fbsc_pkg::*;

  s1_t         s1_nxt;
  logic        bps_ok;
  logic        spc_ok;
  logic [1:0]  bps_code;
  logic [2:0]  spc_log2;
  reason_t     reason;
  logic [31:0] fat_sel;
  logic [31:0] tot_sel;
  logic [21:0] root_num;
  logic [21:0] root_shift;

  // Decode bytes per sector to a shift code
  always_comb begin
    bps_ok   = 1'b1;
    bps_code = 2'd0;
    unique case (bytes_per_sector)
      16'd512:  bps_code = 2'd0;
      16'd1024: bps_code = 2'd1;
      16'd2048: bps_code = 2'd2;
      16'd4096: bps_code = 2'd3;
      default:  bps_ok = 1'b0;
    endcase
  end

  // Decode sectors per cluster to its log2
  always_comb begin
    spc_ok   = 1'b1;
    spc_log2 = 3'd0;
    unique case (sectors_per_cluster)
      8'd1:    spc_log2 = 3'd0;
      8'd2:    spc_log2 = 3'd1;
      8'd4:    spc_log2 = 3'd2;
      8'd8:    spc_log2 = 3'd3;
      8'd16:   spc_log2 = 3'd4;
      8'd32:   spc_log2 = 3'd5;
      8'd64:   spc_log2 = 3'd6;
      8'd128:  spc_log2 = 3'd7;
      default: spc_ok = 1'b0;
    endcase
  end

  // Pick sizes, form root sectors and FAT total
  always_comb begin
    fat_sel    = (fat_sectors_short != 16'd0) ? {16'd0, fat_sectors_short}
                                              : fat_sectors_long;
    tot_sel    = (total_sectors_short != 16'd0) ? {16'd0, total_sectors_short}
                                                : total_sectors_long;
    root_num   = {1'b0, root_entries, 5'd0} + {6'd0, bytes_per_sector} - 22'd1;
    root_shift = root_num >> (SECTOR_MIN_LOG2 + int'(bps_code));
    s1_nxt.reason    = reason;
    s1_nxt.bps_code  = bps_code;
    s1_nxt.spc_log2  = spc_log2;
    s1_nxt.root_secs = root_shift[12:0];
    s1_nxt.fat_total = (fat_count == 8'd2) ? {fat_sel, 1'b0} : {1'b0, fat_sel};
    s1_nxt.rsvd      = reserved_sectors;
    s1_nxt.tot       = tot_sel;
  end

  // Pick the first failing check
  always_comb begin
    if (partition_bytes[63:MIN_PART_LOG2] == '0) begin
      reason = RSN_SMALL;
    end else if (boot_signature != BOOT_SIG) begin
      reason = RSN_NOSIG;
    end else if (!bps_ok) begin
      reason = RSN_SECTOR;
    end else if (!spc_ok) begin
      reason = RSN_CLUSTER;
    end else if (reserved_sectors == 16'd0 || fat_count == 8'd0 || fat_count > 8'd2) begin
      reason = RSN_COUNTS;
    end else if (fat_sel == 32'd0 || tot_sel == 32'd0) begin
      reason = RSN_ZERO;
    end else begin
      reason = RSN_OK;
    end
  end

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
  end

  // Hold the stage payload
  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

endmodule

FILE: rtl/fbsc_geom.sv
// ----------------------------------------------------------------------------
// fbsc_geom
// Second and third stages: geometry sum, then fit test and data sectors.
// ----------------------------------------------------------------------------
module fbsc_geom (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s1_valid_r,
  input  fbsc_pkg::s1_t s1_r,
  output logic          s3_valid_r,
  output fbsc_pkg::s3_t s3_r
);
  import fbsc_pkg::*;

  logic        s2_valid_r;
  s2_t         s2_r;
  s2_t         s2_nxt;
  s3_t         s3_nxt;
  logic [34:0] diff;

  // Sum reserved, FAT and root sectors at full width
  always_comb begin
    s2_nxt.reason   = s1_r.reason;
    s2_nxt.bps_code = s1_r.bps_code;
    s2_nxt.spc_log2 = s1_r.spc_log2;
    s2_nxt.tot      = s1_r.tot;
    s2_nxt.used     = {18'd0, s1_r.rsvd} + {1'b0, s1_r.fat_total}
                    + {21'd0, s1_r.root_secs};
  end

  // Test the fit and take the data sectors
  always_comb begin
    diff            = {3'd0, s2_r.tot} - {1'b0, s2_r.used};
    s3_nxt.bps_code = s2_r.bps_code;
    s3_nxt.spc_log2 = s2_r.spc_log2;
    s3_nxt.data_secs = diff[31:0];
    if (s2_r.reason == RSN_OK && diff[34]) begin
      s3_nxt.reason = RSN_GEOMETRY;
    end else begin
      s3_nxt.reason = s2_r.reason;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // Hold stage payloads
  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
  end

endmodule

FILE: rtl/fbsc_result.sv
// ----------------------------------------------------------------------------
// fbsc_result
// Last stage: cluster count, empty volume test and the result register.
// ----------------------------------------------------------------------------
module fbsc_result (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s3_valid_r,
  input  fbsc_pkg::s3_t s3_r,
  output logic          out_valid_r,
  output logic          out_accepted_r,
  output logic [3:0]    out_reject_reason_r,
  output logic          out_signature_seen_r,
  output logic [19:0]   out_cluster_bytes_r,
  output logic [31:0]   out_cluster_count_r,
  output logic          out_label_r
);
  import fbsc_pkg::*;

  logic [31:0] clusters;
  logic [19:0] cbytes;
  reason_t     reason;
  logic        ok;

  // Divide by the cluster size and settle the final reason
  always_comb begin
    clusters = s3_r.data_secs >> s3_r.spc_log2;
    cbytes   = (20'd1 << (SECTOR_MIN_LOG2 + int'(s3_r.bps_code))) << s3_r.spc_log2;
    if (s3_r.reason == RSN_OK && clusters == 32'd0) begin
      reason = RSN_NOCLUST;
    end else begin
      reason = s3_r.reason;
    end
    ok = (reason == RSN_OK);
  end

  // Raise the strobe for one cycle per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s3_valid_r;
    end
  end

  // Hold the result; zero the sizes of a rejected item
  always_ff @(posedge clk) begin
    out_accepted_r       <= ok;
    out_reject_reason_r  <= reason;
    out_signature_seen_r <= (reason != RSN_SMALL) && (reason != RSN_NOSIG);
    out_cluster_bytes_r  <= ok ? cbytes : 20'd0;
    out_cluster_count_r  <= ok ? clusters : 32'd0;
    out_label_r          <= ok && (clusters >= FAT32_MIN_CLUSTERS);
  end

endmodule

FILE: rtl/fbsc_checker.sv
// ----------------------------------------------------------------------------
// fbsc_checker
// Port-level checks of the FAT boot sector check unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_accepted,
  input logic [3:0]  out_reject_reason,
  input logic        out_signature_seen,
  input logic [19:0] out_cluster_bytes,
  input logic [31:0] out_cluster_count,
  input logic        out_label_at_fat32_offset
);
  import fbsc_pkg::*;

  // Every item taken yields its result after the fixed latency
  `ASSERT_PROP(a_latency, clk, rst_n, start && !busy |-> ##LATENCY out_valid, "result missing")

  // Acceptance and reason agree
  `ASSERT_IMPLY(a_accept_reason, clk, rst_n, out_valid, out_accepted == (out_reject_reason == RSN_OK), "accept and reason disagree")

  // A rejected item carries no sizes
  `ASSERT_IMPLY(a_reject_zero, clk, rst_n, out_valid && !out_accepted, out_cluster_bytes == 20'd0 && out_cluster_count == 32'd0 && !out_label_at_fat32_offset, "rejected item has sizes")

  // Signature is seen exactly when neither early check failed
  `ASSERT_IMPLY(a_sig_seen, clk, rst_n, out_valid, out_signature_seen == (out_reject_reason != RSN_SMALL && out_reject_reason != RSN_NOSIG), "signature flag wrong")

endmodule

bind fat_boot_sector_check_unit fbsc_checker u_fbsc_checker (.*);
